### hdl/mlqs_pkg.sv
// package for the multilevel queue scheduler: payload structs, constants,
// controller/datapath command and status types. no dependencies.
package mlqs_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam logic [7:0] QUANTUM_RST   = 8'd4;
    localparam logic [7:0] THRESHOLD_RST = 8'd3;

    localparam logic CFG_QUANTUM   = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  task_id;
        logic [15:0] burst_length;
        logic [7:0]  task_priority;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [3:0]  ran_task;
        logic        cpu_idle;
        logic        task_done;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } t_out_item;

    typedef struct packed {
        logic load;    // capture input item
        logic exec;    // perform the operation on the captured item
    } t_cmd;

    typedef struct packed {
        logic is_tick;
    } t_status;

endpackage

### hdl/mlqs_ctrl.sv
// controller state machine for the scheduler
// depends on mlqs_pkg
module mlqs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output mlqs_pkg::t_cmd   o_cmd
);
    import mlqs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign busy       = (r_state == S_EXEC);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);
endmodule

### hdl/mlqs_dp.sv
// scheduler datapath: fifos, task tables, time counter, result register
// depends on mlqs_pkg
module mlqs_dp #(
    parameter int MAX_TASKS = mlqs_pkg::MAX_TASKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlqs_pkg::t_cmd       i_cmd,
    input  mlqs_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_strobe,
    output mlqs_pkg::t_out_item  o_result
);
    import mlqs_pkg::*;

    localparam int IW = (MAX_TASKS > 16) ? $clog2(MAX_TASKS) : 4;
    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = AW + 1;

    // fifo index wrap, also for depths that are not a power of two
    function automatic logic [AW-1:0] f_wrap(logic [AW:0] v);
        return (int'(v) >= MAX_TASKS) ? AW'(int'(v) - MAX_TASKS) : v[AW-1:0];
    endfunction

    logic [7:0] r_quantum, r_thresh;
    t_in_item   r_item;
    logic [31:0] r_now;

    logic [IW-1:0] r_hq [MAX_TASKS];
    logic [IW-1:0] r_lq [MAX_TASKS];
    logic [AW-1:0] r_hhead, r_lhead;
    logic [CW-1:0] r_hcnt, r_lcnt;

    logic [15:0] r_rem   [MAX_TASKS];
    logic [15:0] r_burst [MAX_TASKS];
    logic [31:0] r_arr   [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_active;

    logic [IW-1:0] r_run;
    logic r_run_v, r_run_hi, r_rot;
    logic [7:0] r_qused;

    // fifo tail and next head positions
    logic [AW-1:0] h_tail, l_tail, h_head_nx, l_head_nx;
    assign h_tail    = f_wrap({1'b0, r_hhead} + r_hcnt);
    assign l_tail    = f_wrap({1'b0, r_lhead} + r_lcnt);
    assign h_head_nx = f_wrap({1'b0, r_hhead} + CW'(1));
    assign l_head_nx = f_wrap({1'b0, r_lhead} + CW'(1));

    // arrival decode
    logic [IW-1:0] a_id;
    logic          a_in_rng, a_ok, a_high;
    logic [15:0]   a_burst;
    assign a_id     = IW'(r_item.task_id);
    assign a_in_rng = (int'(r_item.task_id) < MAX_TASKS);
    assign a_ok     = a_in_rng && !r_active[a_id[AW-1:0]];
    assign a_high   = r_item.task_priority < r_thresh;
    assign a_burst  = (r_item.burst_length == 16'd0) ? 16'd1 : r_item.burst_length;

    // tick: rotation push then pick
    logic          h_push_rot;
    logic [CW-1:0] hcnt_eff;
    logic          need_pick, pick_h, pick_l, idle;
    logic [IW-1:0] cur;
    logic [AW-1:0] cur_a;
    logic [15:0]   rem_new;
    logic [31:0]   now_inc, ta;
    logic [7:0]    q_new, q_eff;
    logic          done;
    logic          n_rot;
    t_out_item     n_result;

    assign h_push_rot = r_rot && (r_hcnt < CW'(MAX_TASKS));
    assign hcnt_eff   = r_hcnt + CW'(h_push_rot);
    assign need_pick  = !r_run_v || r_rot;
    // a rotated task pushed into an empty queue is popped straight back
    assign pick_h     = need_pick && (hcnt_eff != '0);
    assign pick_l     = need_pick && !pick_h && (r_lcnt != '0);
    assign idle       = need_pick && !pick_h && !pick_l;
    always_comb begin
        if (pick_h) cur = (r_hcnt == '0) ? r_run : r_hq[r_hhead];
        else if (pick_l) cur = r_lq[r_lhead];
        else cur = r_run;
    end
    assign cur_a   = cur[AW-1:0];
    assign rem_new = (r_rem[cur_a] == 16'd0) ? 16'd0 : r_rem[cur_a] - 16'd1;
    assign now_inc = r_now + 32'd1;
    assign ta      = now_inc - r_arr[cur_a];
    assign q_eff   = need_pick ? 8'd0 : r_qused;
    assign q_new   = (q_eff == 8'hff) ? q_eff : q_eff + 8'd1;
    assign done    = (rem_new == 16'd0);

    wire tick = i_cmd.exec && r_item.func == FUNC_TICK;
    wire arr  = i_cmd.exec && r_item.func == FUNC_ARRIVAL;
    wire run_hi_new = pick_h ? 1'b1 : (pick_l ? 1'b0 : r_run_hi);

    assign n_rot = !idle && !done && run_hi_new && (q_new >= r_quantum);

    always_comb begin
        n_result = '0;
        if (arr) n_result.status = !a_ok;
        if (tick) begin
            n_result.cpu_idle  = idle;
            n_result.ran_task  = idle ? 4'd0 : cur[3:0];
            n_result.task_done = !idle && done;
            if (!idle && done) begin
                n_result.turnaround = ta;
                n_result.waiting    = ta - {16'd0, r_burst[cur_a]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (tick && !idle) r_rem[cur_a] <= rem_new;
        if (arr && a_ok) begin
            r_rem[a_id[AW-1:0]]   <= a_burst;
            r_burst[a_id[AW-1:0]] <= a_burst;
            r_arr[a_id[AW-1:0]]   <= r_now;
            if (a_high) begin
                if (r_hcnt < CW'(MAX_TASKS))
                    r_hq[h_tail] <= a_id;
            end else if (r_lcnt < CW'(MAX_TASKS)) begin
                r_lq[l_tail] <= a_id;
            end
        end
        if (tick && h_push_rot && r_hcnt != '0)
            r_hq[h_tail] <= r_run;
        o_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RST;
            r_thresh  <= THRESHOLD_RST;
            r_now <= '0; r_hhead <= '0; r_lhead <= '0; r_hcnt <= '0; r_lcnt <= '0;
            r_active <= '0; r_run <= '0; r_run_v <= 1'b0; r_run_hi <= 1'b0;
            r_rot <= 1'b0; r_qused <= '0; o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.exec;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QUANTUM) r_quantum <= i_cfg_data;
                else r_thresh <= i_cfg_data;
            end
            if (arr && a_ok) begin
                r_active[a_id[AW-1:0]] <= 1'b1;
                if (a_high) begin
                    if (r_hcnt < CW'(MAX_TASKS)) r_hcnt <= r_hcnt + 1'b1;
                end else if (r_lcnt < CW'(MAX_TASKS)) r_lcnt <= r_lcnt + 1'b1;
            end
            if (tick) begin
                r_now <= now_inc;
                r_rot <= n_rot;
                if (pick_h) begin
                    if (r_hcnt != '0) r_hhead <= h_head_nx;
                    r_hcnt <= hcnt_eff - 1'b1;
                end else if (h_push_rot) begin
                    r_hcnt <= hcnt_eff;
                end
                if (pick_l) begin
                    r_lhead <= l_head_nx;
                    r_lcnt  <= r_lcnt - 1'b1;
                end
                if (idle) begin
                    r_run_v <= 1'b0;
                end else begin
                    r_run <= cur;
                    if (done) begin
                        r_active[cur_a] <= 1'b0;
                        r_run_v <= 1'b0; r_run_hi <= 1'b0; r_qused <= '0;
                    end else begin
                        r_run_v <= 1'b1; r_run_hi <= run_hi_new; r_qused <= q_new;
                    end
                end
            end
        end
    end
endmodule

### hdl/multilevel_queue_scheduler_top.sv
// multilevel queue scheduler: high round-robin queue over low fcfs queue
// result: after start is accepted the controller enters S_EXEC, and o_strobe is registered from it
// start is taken only in S_IDLE; busy is high for one cycle after start
// reset: synchronous active low, empties both queues, clears time and tasks
// the receiver cannot stall; each result is shown for one cycle on o_strobe
module multilevel_queue_scheduler_top #(
    parameter int MAX_TASKS = mlqs_pkg::MAX_TASKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mlqs_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_strobe,
    output mlqs_pkg::t_out_item  o_result
);
    import mlqs_pkg::*;

    t_cmd w_cmd;

    // controller sequences capture and execute of each transaction
    mlqs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_cmd(w_cmd)
    );

    // datapath holds queues, per-task tables and the result register
    mlqs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_result(o_result)
    );
endmodule

### hdl/mlqs_checker.sv
// port-level checker for the scheduler, bound to the top level
// depends on mlqs_pkg
module mlqs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input mlqs_pkg::t_out_item o_result
);
    import mlqs_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy missing after start");
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe) else $error("result strobe missing");
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.cpu_idle) |-> !o_result.task_done)
        else $error("idle tick reports done");
    a_status_only_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status) |-> !o_result.cpu_idle && !o_result.task_done)
        else $error("reject mixed with tick result");
endmodule

bind multilevel_queue_scheduler_top mlqs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_result(o_result)
);
